// ===== sv/lsr_pkg.sv =====
package lsr_pkg;

  // Default geometry: source row length and strip length.
  localparam int unsigned SRC_COUNT_DEF = 16;
  localparam int unsigned OUT_COUNT_DEF = 200;

  // Channel and pixel layout (red in the top byte, blue in the bottom byte).
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CHAN_COUNT = 3;
  localparam int unsigned PIX_W      = CHAN_W * CHAN_COUNT;

  // Full-scale value of the interpolation fraction.
  localparam int unsigned FRAC_SCALE = 255;

  // Input actions.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

endpackage

// ===== sv/led_strip_resampler.sv =====
// LED strip resampler.
// The input channel (in_valid_i / in_ready_o) carries load and fetch transactions.
// A load writes one source pixel into the row store and finishes in the cycle it is
// accepted; loads whose index is past the row length are dropped. A fetch returns the
// color of one strip position on the output channel (out_valid_o / out_ready_i).
// The cfg_we_i / cfg_wdata_i port sets the mode: tile the row, or stretch it with
// linear interpolation between neighboring source pixels.
// A fetch runs on one shared multiplier under a small sequencer. A division by the row
// or strip length is a reciprocal multiply followed by a remainder step; tiling needs
// one division, stretching a second one for the fraction. Then come three store steps,
// three blend steps, one per channel, and a step that loads the output register.
// The block takes no new transaction until a fetch has loaded the output register.
// The result sits in an output register, so a new transaction is taken while it waits;
// a fetch that finishes while the register is still full holds until the receiver
// takes the older result. Reset clears the mode to tiling and marks every source pixel
// black through per-entry valid bits; no clearing pass is needed.
module led_strip_resampler #(
  parameter int unsigned SRC_COUNT = lsr_pkg::SRC_COUNT_DEF,
  parameter int unsigned OUT_COUNT = lsr_pkg::OUT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] index_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] strip_position_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o
);

  localparam int unsigned CW  = lsr_pkg::CHAN_W;
  localparam int unsigned PW  = lsr_pkg::PIX_W;
  localparam int unsigned AW  = $clog2(SRC_COUNT);
  localparam int unsigned DW  = $clog2(lsr_pkg::FRAC_SCALE * (OUT_COUNT + SRC_COUNT) + 1);
  localparam int unsigned MAXDEN = (OUT_COUNT > SRC_COUNT) ? OUT_COUNT : SRC_COUNT;
  // Reciprocal shift: exact quotients for every numerator below 2**DW.
  localparam int unsigned RS  = DW + $clog2(MAXDEN);
  localparam int unsigned MW  = RS + 1;

  localparam logic [DW-1:0]  SRC_DW     = DW'(SRC_COUNT);
  localparam logic [DW-1:0]  OUT_DW     = DW'(OUT_COUNT);
  localparam logic [DW-1:0]  SCALE_DW   = DW'(lsr_pkg::FRAC_SCALE);
  localparam logic [MW-1:0]  RECIP_SRC  =
    MW'(((64'd1 << RS) + 64'(SRC_COUNT) - 64'd1) / 64'(SRC_COUNT));
  localparam logic [MW-1:0]  RECIP_OUT  =
    MW'(((64'd1 << RS) + 64'(OUT_COUNT) - 64'd1) / 64'(OUT_COUNT));
  localparam logic [AW-1:0]  LAST_ADDR  = AW'(SRC_COUNT - 1);
  localparam logic [8:0]     SRC_LIMIT  = 9'(SRC_COUNT);
  localparam logic [1:0]     CH_LAST    = 2'(lsr_pkg::CHAN_COUNT - 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV_SCALE = 4'd1;
  localparam logic [3:0] S_DIV_REM   = 4'd2;
  localparam logic [3:0] S_DIV_FRAC  = 4'd3;
  localparam logic [3:0] S_RD_LOW    = 4'd4;
  localparam logic [3:0] S_RD_NEXT   = 4'd5;
  localparam logic [3:0] S_WAIT      = 4'd6;
  localparam logic [3:0] S_BLEND     = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]           state_q, state_d;
  logic                 ext_mode_q, ext_mode_d;
  logic [SRC_COUNT-1:0] valid_q, valid_d;
  logic                 rvalid_q;
  logic [7:0]           idx_q, idx_d;
  logic [DW-1:0]        num_q, num_d;
  logic [DW-1:0]        quot_q, quot_d;
  logic [AW-1:0]        low_q, low_d;
  logic [AW-1:0]        next_q, next_d;
  logic [CW-1:0]        frac_q, frac_d;
  logic [PW-1:0]        pix_a_q, pix_a_d;
  logic [PW-1:0]        pix_b_q, pix_b_d;
  logic [PW-1:0]        res_q, res_d;
  logic [1:0]           ch_q, ch_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_pos_q, out_pos_d;
  logic [PW-1:0]        out_pix_q, out_pix_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [PW-1:0]        ram_rdata;
  logic [PW-1:0]        rd_pix;

  // Row store with registered read.
  lsr_ram #(
    .WIDTH(PW),
    .DEPTH(SRC_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(index_i[AW-1:0]),
    .wdata_i({red_in_i, green_in_i, blue_in_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_raddr = (state_q == S_RD_LOW) ? low_q : next_q;
  // An entry never loaded since reset reads as black.
  assign rd_pix    = rvalid_q ? ram_rdata : '0;

  // Blend operands of the current channel.
  logic [CW-1:0]   ch_a;
  logic [CW-1:0]   ch_b;
  logic            ch_gt;
  logic [CW-1:0]   ch_mag;

  always_comb begin
    ch_a   = pix_a_q[CW-1:0];
    ch_b   = pix_b_q[CW-1:0];
    ch_gt  = (ch_b > ch_a);
    ch_mag = ch_gt ? (ch_b - ch_a) : (ch_a - ch_b);
  end

  // Shared multiplier: reciprocal divisions first, then the channel blends.
  logic [DW-1:0]    mul_a;
  logic [MW-1:0]    mul_b;
  logic [DW+MW-1:0] mul_p;
  logic [DW-1:0]    quot;
  logic [2*CW-1:0]  ch_prod;
  logic [CW-1:0]    ch_res;
  logic [DW-1:0]    div_rem;
  logic [DW-1:0]    frac_num;
  logic [AW-1:0]    low_clamp;
  logic [AW-1:0]    next_sel;

  always_comb begin
    mul_a = DW'(ch_mag);
    mul_b = MW'(frac_q);
    if (state_q == S_DIV_SCALE) begin
      mul_a = num_q;
      mul_b = ext_mode_q ? RECIP_OUT : RECIP_SRC;
    end else if (state_q == S_DIV_FRAC) begin
      mul_a = num_q;
      mul_b = RECIP_OUT;
    end
    mul_p     = {{MW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};
    quot      = mul_p[RS +: DW];
    ch_prod   = mul_p[2*CW-1:0];
    ch_res    = ch_gt ? (ch_a + ch_prod[2*CW-1:CW]) : (ch_a - ch_prod[2*CW-1:CW]);
    // Remainder of the registered quotient; scaled by full scale for the fraction.
    div_rem   = num_q - (ext_mode_q ? quot_q * OUT_DW : quot_q * SRC_DW);
    frac_num  = div_rem * SCALE_DW;
    low_clamp = (quot_q >= SRC_DW) ? LAST_ADDR : quot_q[AW-1:0];
    next_sel  = (low_q < LAST_ADDR) ? low_q + 1'b1 : low_q;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ext_mode_d  = ext_mode_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    num_d       = num_q;
    quot_d      = quot_q;
    low_d       = low_q;
    next_d      = next_q;
    frac_d      = frac_q;
    pix_a_d     = pix_a_q;
    pix_b_d     = pix_b_q;
    res_d       = res_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_pix_d   = out_pix_q;
    ram_we      = 1'b0;

    if (cfg_we_i) begin
      ext_mode_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = index_i;
          if (action_i == lsr_pkg::ACT_LOAD) begin
            if ({1'b0, index_i} < SRC_LIMIT) begin
              ram_we                    = 1'b1;
              valid_d[index_i[AW-1:0]]  = 1'b1;
            end
          end else begin
            // Stretch divides idx*SRC by OUT; tiling divides idx by SRC.
            num_d   = ext_mode_q ? DW'(index_i) * SRC_DW : DW'(index_i);
            state_d = S_DIV_SCALE;
          end
        end
      end
      S_DIV_SCALE: begin
        quot_d  = quot;
        state_d = S_DIV_REM;
      end
      S_DIV_REM: begin
        if (ext_mode_q) begin
          // Scaled remainder times full scale, divided again for the fraction.
          low_d   = low_clamp;
          num_d   = frac_num;
          state_d = S_DIV_FRAC;
        end else begin
          low_d   = div_rem[AW-1:0];
          next_d  = div_rem[AW-1:0];
          frac_d  = '0;
          state_d = S_RD_LOW;
        end
      end
      S_DIV_FRAC: begin
        frac_d  = quot[CW-1:0];
        next_d  = next_sel;
        state_d = S_RD_LOW;
      end
      S_RD_LOW: begin
        state_d = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        pix_a_d = rd_pix;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        pix_b_d = rd_pix;
        ch_d    = '0;
        state_d = S_BLEND;
      end
      S_BLEND: begin
        // Blue first; results shift in from the top so red ends in the top byte.
        res_d   = {ch_res, res_q[PW-1:CW]};
        pix_a_d = pix_a_q >> CW;
        pix_b_d = pix_b_q >> CW;
        ch_d    = ch_q + 1'b1;
        if (ch_q == CH_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = idx_q;
          out_pix_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ext_mode_q  <= 1'b0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
    end else begin
      state_q     <= state_d;
      ext_mode_q  <= ext_mode_d;
      valid_q     <= valid_d;
      rvalid_q    <= valid_q[ram_raddr];
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    num_q     <= num_d;
    quot_q    <= quot_d;
    low_q     <= low_d;
    next_q    <= next_d;
    frac_q    <= frac_d;
    pix_a_q   <= pix_a_d;
    pix_b_q   <= pix_b_d;
    res_q     <= res_d;
    out_pos_q <= out_pos_d;
    out_pix_q <= out_pix_d;
  end

  assign out_valid_o      = out_valid_q;
  assign strip_position_o = out_pos_q;
  assign red_out_o        = out_pix_q[3*CW-1:2*CW];
  assign green_out_o      = out_pix_q[2*CW-1:CW];
  assign blue_out_o       = out_pix_q[CW-1:0];

  // A fetch transaction keeps the input side closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == lsr_pkg::ACT_FETCH) |=> !in_ready_o)
    else $error("input accepted while a fetch is in progress");

  // The reciprocal quotient leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_REM) |-> (div_rem < (ext_mode_q ? OUT_DW : SRC_DW)))
    else $error("divider remainder out of range");

  // Store addresses lie in the row, and the neighbor is the same or the next pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_LOW) |->
      (({1'b0, low_q} < (AW+1)'(SRC_COUNT)) &&
       (next_q == low_q || {1'b0, next_q} == {1'b0, low_q} + 1'b1)))
    else $error("store read address out of range");

  // A load transaction never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == lsr_pkg::ACT_LOAD && !out_valid_o)
      |=> !out_valid_o)
    else $error("result produced by a load");

endmodule

// ===== sv/lsr_ram.sv =====
module lsr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/led_strip_resampler_tb.sv =====
`timescale 1ns / 100ps

module led_strip_resampler_tb;

  localparam int unsigned SRC     = lsr_pkg::SRC_COUNT_DEF;
  localparam int unsigned OUTN    = lsr_pkg::OUT_COUNT_DEF;
  localparam int unsigned LIMIT   = 1_000_000;
  localparam int unsigned SETTLE  = 60;
  localparam int unsigned ITEMS   = 900;
  localparam int unsigned PHASES  = 5;

  localparam logic MODE_TILE    = 1'b0;
  localparam logic MODE_STRETCH = 1'b1;

  // One strip color as it leaves the block.
  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } strip_color_t;

  // Keeps a private copy of the source row and the mode, predicts the color of every
  // accepted fetch and checks the colors that come out in order.
  class strip_color_checker;
    logic [lsr_pkg::PIX_W-1:0] row_pixels [SRC];
    logic                      stretch_mode;
    strip_color_t              expected_colors [$];
    int unsigned               error_count;

    function new();
      foreach (row_pixels[k]) row_pixels[k] = '0;
      stretch_mode = MODE_TILE;
      error_count  = 0;
    endfunction

    function void report_mismatch(string what);
      if (error_count < 100) $display("MISMATCH: %s", what);
      error_count++;
    endfunction

    function int unsigned pending();
      return expected_colors.size();
    endfunction

    function void set_mode(logic m);
      stretch_mode = m;
    endfunction

    // Blends one channel toward its neighbor by frac/256, truncating toward a.
    function logic [7:0] blend_channel(int unsigned a, int unsigned b, int unsigned frac);
      if (b > a) return 8'(a + (((b - a) * frac) >> 8));
      return 8'(a - (((a - b) * frac) >> 8));
    endfunction

    function strip_color_t predict_color(logic [7:0] idx);
      strip_color_t              c;
      int unsigned               scaled, low, nxt, frac;
      logic [lsr_pkg::PIX_W-1:0] pa, pb;
      c.pos = idx;
      if (stretch_mode == MODE_TILE) begin
        pa = row_pixels[idx % SRC];
        {c.red, c.green, c.blue} = pa;
      end else begin
        scaled = int'(idx) * SRC;
        low    = scaled / OUTN;
        frac   = (((scaled % OUTN) * lsr_pkg::FRAC_SCALE) / OUTN) & 8'hFF;
        if (low >= SRC) low = SRC - 1;
        nxt = (low + 1 >= SRC) ? SRC - 1 : low + 1;
        pa = row_pixels[low];
        pb = row_pixels[nxt];
        c.red   = blend_channel(pa[23:16], pb[23:16], frac);
        c.green = blend_channel(pa[15:8],  pb[15:8],  frac);
        c.blue  = blend_channel(pa[7:0],   pb[7:0],   frac);
      end
      return c;
    endfunction

    // Called for each accepted input transaction.
    function void note_transaction(logic act, logic [7:0] idx,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (act == lsr_pkg::ACT_LOAD) begin
        if (idx < SRC) row_pixels[idx] = {r, g, b};
      end else begin
        expected_colors.push_back(predict_color(idx));
      end
    endfunction

    // Called for each accepted output transaction.
    function void check_color(strip_color_t got);
      strip_color_t want;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected color for position %0d", got.pos));
        return;
      end
      want = expected_colors.pop_front();
      if (got.pos !== want.pos)
        report_mismatch($sformatf("position got %0d want %0d", got.pos, want.pos));
      if (got.red !== want.red)
        report_mismatch($sformatf("pos %0d red got %h want %h", want.pos, got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("pos %0d green got %h want %h",
                                  want.pos, got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("pos %0d blue got %h want %h",
                                  want.pos, got.blue, want.blue));
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       action_i    = lsr_pkg::ACT_LOAD;
  logic [7:0] index_i     = '0;
  logic [7:0] red_in_i    = '0;
  logic [7:0] green_in_i  = '0;
  logic [7:0] blue_in_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] strip_position_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;

  strip_color_checker book = new();
  int unsigned        cycle_count = 0;
  int unsigned        burst_left  = 0;

  led_strip_resampler dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .index_i          (index_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .strip_position_o (strip_position_o),
    .red_out_o        (red_out_o),
    .green_out_o      (green_out_o),
    .blue_out_o       (blue_out_o)
  );

  // Clock generation.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output monitor: values are read before this edge updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.check_color({strip_position_o, red_out_o, green_out_o, blue_out_o});
  end

  // Idle length: mostly zero or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: long open stretches mixed with stalls of random length.
  initial begin
    int unsigned hold, stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 99) < 25) begin
        hold  = $urandom_range(20, 80);
        stall = 0;
      end else begin
        hold  = $urandom_range(1, 4);
        stall = pick_gap();
      end
      out_ready_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Presents one input transaction and returns in the step of its acceptance.
  task automatic send_item(input logic act, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    index_i    <= idx;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_transaction(act, idx, r, g, b);
  endtask

  // Drops valid and waits until every predicted color has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  // Mode change only with the block idle; loads finish at once, the pause covers the rest.
  task automatic write_mode(input logic m);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    book.set_mode(m);
  endtask

  function automatic logic [7:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // One random transaction; counted is clear when the block would just drop it.
  task automatic send_random(output bit counted);
    logic        act;
    logic [7:0]  idx;
    int unsigned r, gap;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
    end
    act = (r < 35) ? lsr_pkg::ACT_LOAD : lsr_pkg::ACT_FETCH;
    r = $urandom_range(0, 99);
    if (act == lsr_pkg::ACT_LOAD) begin
      idx = (r < 90) ? 8'($urandom_range(0, SRC - 1)) : 8'($urandom_range(SRC, 255));
    end else if (r < 70) begin
      idx = 8'($urandom_range(0, OUTN - 1));
    end else if (r < 85) begin
      idx = 8'($urandom_range(OUTN - 20, OUTN - 1));
    end else begin
      idx = 8'($urandom_range(OUTN, 255));
    end
    send_item(act, idx, pick_channel(), pick_channel(), pick_channel(), gap);
    counted = (act == lsr_pkg::ACT_FETCH) || (idx < SRC);
  endtask

  // Main sequence.
  initial begin
    logic        plan [PHASES];
    int unsigned phase_items;
    bit          counted;
    plan = '{MODE_STRETCH, MODE_TILE, MODE_STRETCH, MODE_TILE, MODE_STRETCH};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tiling with the row still black after reset.
    send_item(lsr_pkg::ACT_FETCH, 8'd0, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1);
    // Loads at both ends of the row, and two past it that must be dropped.
    send_item(lsr_pkg::ACT_LOAD, 8'd0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_item(lsr_pkg::ACT_LOAD, 8'd1, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_LOAD, 8'd15, 8'h00, 8'h80, 8'hFF, 2);
    send_item(lsr_pkg::ACT_LOAD, 8'd14, 8'hFF, 8'h7F, 8'h00, 0);
    send_item(lsr_pkg::ACT_LOAD, 8'd2, 8'hFF, 8'h40, 8'h10, 0);
    send_item(lsr_pkg::ACT_LOAD, 8'd16, 8'hAA, 8'h55, 8'hAA, 0);
    send_item(lsr_pkg::ACT_LOAD, 8'd255, 8'h55, 8'hAA, 8'h55, 0);
    // Tiling: wrap-around and positions past the strip.
    send_item(lsr_pkg::ACT_FETCH, 8'd15, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd16, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd31, 8'h00, 8'h00, 8'h00, 3);
    send_item(lsr_pkg::ACT_FETCH, 8'd199, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd255, 8'h00, 8'h00, 8'h00, 0);

    // Stretching: exact hit, blends both ways, clamped neighbor, past the strip.
    write_mode(MODE_STRETCH);
    send_item(lsr_pkg::ACT_FETCH, 8'd0, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd6, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd20, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd187, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd199, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd200, 8'h00, 8'h00, 8'h00, 0);
    send_item(lsr_pkg::ACT_FETCH, 8'd255, 8'h00, 8'h00, 8'h00, 0);

    // Random phases under alternating modes.
    for (int p = 0; p < PHASES; p++) begin
      write_mode(plan[p]);
      phase_items = 0;
      // Usually start with a fresh row of random colors.
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < SRC; k++) begin
          send_item(lsr_pkg::ACT_LOAD, 8'(k), pick_channel(), pick_channel(),
                    pick_channel(), pick_gap());
          phase_items++;
        end
      end
      while (phase_items < ITEMS / PHASES) begin
        send_random(counted);
        if (counted) phase_items++;
        // Sender holds off until the output side has caught up.
        if (p == 1 && phase_items == 90) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (book.error_count == 0 && book.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (book.pending() != 0)
        book.report_mismatch($sformatf("%0d colors never arrived", book.pending()));
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
